@@ sv/ffa_pkg.sv @@
// Shared types, state codes and status bundle of the first-fit allocator.
package ffa_pkg;

  localparam int CFG_W  = 11;
  localparam int BYTE_W = 14;
  localparam int UNIT_W = 10;

  typedef logic [4:0] state_t;

  localparam state_t ST_CLR   = 5'd0;
  localparam state_t ST_IDLE  = 5'd1;
  localparam state_t ST_WRD   = 5'd2;
  localparam state_t ST_WEV   = 5'd3;
  localparam state_t ST_ASPL  = 5'd4;
  localparam state_t ST_AS3   = 5'd5;
  localparam state_t ST_ALNK  = 5'd6;
  localparam state_t ST_RPLC  = 5'd7;
  localparam state_t ST_RTAIL = 5'd8;
  localparam state_t ST_RLNK  = 5'd9;
  localparam state_t ST_C1    = 5'd10;
  localparam state_t ST_C2    = 5'd11;
  localparam state_t ST_C3    = 5'd12;
  localparam state_t ST_C5    = 5'd13;
  localparam state_t ST_C6    = 5'd14;
  localparam state_t ST_FIN   = 5'd15;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef struct packed {
    logic in_valid;
    logic func;
    logic rel_bad;
    logic walk_end;
    logic cur_valid;
    logic fit;
    logic dup;
    logic precedes;
    logic split;
    logic has_next;
    logic prev_valid;
    logic clr_last;
    logic out_busy;
  } stat_t;

endpackage

@@ sv/ffa_if.sv @@
// Request and response channel interfaces of the allocator.
interface ffa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [ffa_pkg::BYTE_W-1:0] request_bytes;
  logic [ffa_pkg::UNIT_W-1:0] release_unit;
  modport source (output valid, func, request_bytes, release_unit, input ready);
  modport sink   (input valid, func, request_bytes, release_unit, output ready);
endinterface

interface ffa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [ffa_pkg::UNIT_W-1:0] payload_unit;
  modport source (output valid, ok, payload_unit, input ready);
  modport sink   (input valid, ok, payload_unit, output ready);
endinterface

@@ sv/first_fit_freelist_allocator.sv @@
// Top level of the first-fit free-list allocator with coalescing.
//
//  Channel   Direction  Contents
//  in_req    sink       func, request_bytes, release_unit
//  out_rsp   source     ok, payload_unit
//  cfg_*     write      arena_units
//
// Each request passes through accept, a read and an evaluate step per free block visited,
// one more read step when the walk runs off the list, the update steps and finish; the walk
// reads the headers through the single read port of the stores.
// After reset and after every configuration write, a clearing pass over all ARENA_UNITS
// header entries runs during which no request is taken. A new request is taken once the previous result
// sits in the output register; a stalled output holds the sequencer in its finish step.
module first_fit_freelist_allocator #(
  parameter int ARENA_UNITS = 1024,
  parameter int UNIT_BYTES  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ffa_pkg::CFG_W-1:0] cfg_wdata,
  ffa_req_if.sink                   in_req,
  ffa_rsp_if.source                 out_rsp
);

  ffa_pkg::state_t cmd;
  ffa_pkg::stat_t  stat;

  ffa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_we (cfg_we),
    .stat   (stat),
    .cmd    (cmd)
  );

  ffa_dp #(
    .ARENA_UNITS (ARENA_UNITS),
    .UNIT_BYTES  (UNIT_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .in_req    (in_req),
    .out_rsp   (out_rsp)
  );

endmodule

@@ sv/ffa_ctrl.sv @@
// Sequencer that walks the free list and orders the store updates.
module ffa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  ffa_pkg::stat_t  stat,
  output ffa_pkg::state_t cmd
);

  ffa_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffa_pkg::ST_CLR:   if (stat.clr_last) state_nxt = ffa_pkg::ST_IDLE;
      ffa_pkg::ST_IDLE: begin
        if (stat.in_valid) begin
          if (stat.func == ffa_pkg::FUNC_RELEASE && stat.rel_bad) state_nxt = ffa_pkg::ST_FIN;
          else state_nxt = ffa_pkg::ST_WRD;
        end
      end
      ffa_pkg::ST_WRD: begin
        if (!stat.walk_end) state_nxt = ffa_pkg::ST_WEV;
        else if (stat.func == ffa_pkg::FUNC_ALLOC || stat.cur_valid) state_nxt = ffa_pkg::ST_FIN;
        else state_nxt = ffa_pkg::ST_RTAIL;
      end
      ffa_pkg::ST_WEV: begin
        if (stat.func == ffa_pkg::FUNC_ALLOC) begin
          state_nxt = stat.fit ? ffa_pkg::ST_ASPL : ffa_pkg::ST_WRD;
        end else if (stat.dup) begin
          state_nxt = ffa_pkg::ST_FIN;
        end else begin
          state_nxt = stat.precedes ? ffa_pkg::ST_RPLC : ffa_pkg::ST_WRD;
        end
      end
      ffa_pkg::ST_ASPL:  state_nxt = stat.split ? ffa_pkg::ST_AS3 : ffa_pkg::ST_ALNK;
      ffa_pkg::ST_AS3:   state_nxt = ffa_pkg::ST_ALNK;
      ffa_pkg::ST_ALNK:  state_nxt = ffa_pkg::ST_FIN;
      ffa_pkg::ST_RPLC:  state_nxt = ffa_pkg::ST_RLNK;
      ffa_pkg::ST_RTAIL: state_nxt = ffa_pkg::ST_RLNK;
      ffa_pkg::ST_RLNK:  state_nxt = ffa_pkg::ST_C1;
      ffa_pkg::ST_C1:    state_nxt = ffa_pkg::ST_C2;
      ffa_pkg::ST_C2:    state_nxt = stat.has_next ? ffa_pkg::ST_C3 : ffa_pkg::ST_C5;
      ffa_pkg::ST_C3:    state_nxt = ffa_pkg::ST_C5;
      ffa_pkg::ST_C5:    state_nxt = stat.prev_valid ? ffa_pkg::ST_C6 : ffa_pkg::ST_FIN;
      ffa_pkg::ST_C6:    state_nxt = ffa_pkg::ST_FIN;
      ffa_pkg::ST_FIN:   if (!stat.out_busy) state_nxt = ffa_pkg::ST_IDLE;
      default:           state_nxt = ffa_pkg::ST_CLR;
    endcase
    if (cfg_we) state_nxt = ffa_pkg::ST_CLR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ffa_pkg::ST_CLR;
    else state_r <= state_nxt;
  end

  assign cmd = state_r;

endmodule

@@ sv/ffa_dp.sv @@
// Datapath: header stores, list pointers, size arithmetic and result register.
module ffa_dp #(
  parameter int ARENA_UNITS = 1024,
  parameter int UNIT_BYTES  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ffa_pkg::CFG_W-1:0] cfg_wdata,
  input  ffa_pkg::state_t           cmd,
  output ffa_pkg::stat_t            stat,
  ffa_req_if.sink                   in_req,
  ffa_rsp_if.source                 out_rsp
);

  localparam int AW    = $clog2(ARENA_UNITS);
  localparam int LW    = AW + 1;
  localparam int STW   = $clog2(ARENA_UNITS + 1);
  localparam int TW    = ffa_pkg::BYTE_W + 1;
  localparam int SH    = TW + 7;
  localparam int RW    = SH - 2;
  localparam int RECIP = (2 ** SH + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam int CW    = ((AW > TW) ? AW : TW) + 2;
  localparam int ARST  = (ARENA_UNITS > 2047) ? 2047 : ARENA_UNITS;

  localparam logic [CW-1:0]  A_C     = CW'(ARENA_UNITS);
  localparam logic [RW-1:0]  RECIP_V = RW'(RECIP);
  localparam logic [STW-1:0] STEP_MX = STW'(ARENA_UNITS);

  logic [AW-1:0] bs_mem [ARENA_UNITS];
  logic [LW-1:0] nf_mem [ARENA_UNITS];

  logic [AW-1:0] bs_q;
  logic [LW-1:0] nf_q;
  logic [AW-1:0] rd_addr;
  logic          bs_we, nf_we;
  logic [AW-1:0] bs_wa, nf_wa, bs_wd;
  logic [LW-1:0] nf_wd;

  logic [ffa_pkg::CFG_W-1:0] arena_r;
  logic [AW-1:0]             clr_r;
  logic [LW-1:0]             head_r, cur_r, prev_r, link_r, nfc_r, nxn_r;
  logic [AW-1:0]             c_r, node_r, sz_r, bsn_r;
  logic [TW-1:0]             need_r;
  logic [STW-1:0]            steps_r;
  logic                      func_r;
  logic                      res_ok_r;
  logic [ffa_pkg::UNIT_W-1:0] res_pay_r;
  logic                      ov_r, ok_r;
  logic [ffa_pkg::UNIT_W-1:0] pay_r;

  logic                      in_fire;
  logic [TW-1:0]             t_bytes;
  logic [TW+RW-1:0]          prod;
  logic [CW-1:0]             cfg_ext, split_sum, split_ix, adj_n, adj_p;
  logic [ffa_pkg::CFG_W-1:0] cfg_cl;
  logic [AW-1:0]             n_unit;

  assign in_req.ready = (cmd == ffa_pkg::ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;

  assign t_bytes = TW'(in_req.request_bytes) + TW'(UNIT_BYTES - 1);
  assign prod    = t_bytes * RECIP_V;

  assign cfg_ext = CW'(cfg_wdata);
  always_comb begin
    if (cfg_ext < CW'(2)) cfg_cl = ffa_pkg::CFG_W'(2);
    else if (cfg_ext > A_C) cfg_cl = ffa_pkg::CFG_W'(ARST);
    else cfg_cl = cfg_wdata;
  end

  assign split_sum = CW'(c_r) + CW'(1) + CW'(need_r);
  assign split_ix  = (split_sum >= A_C) ? (split_sum - A_C) : split_sum;
  assign n_unit    = split_ix[AW-1:0];
  assign adj_n     = CW'(node_r) + CW'(1) + CW'(bsn_r);
  assign adj_p     = CW'(prev_r[AW-1:0]) + CW'(1) + CW'(bs_q);

  always_comb begin
    stat.in_valid   = in_req.valid;
    stat.func       = (cmd == ffa_pkg::ST_IDLE) ? in_req.func : func_r;
    stat.rel_bad    = (in_req.release_unit == '0) ||
                      (ffa_pkg::CFG_W'(in_req.release_unit) >= arena_r);
    stat.walk_end   = !cur_r[AW] || (steps_r == STEP_MX);
    stat.cur_valid  = cur_r[AW];
    stat.fit        = CW'(need_r) <= CW'(bs_q);
    stat.dup        = (c_r == node_r);
    stat.precedes   = (node_r < c_r);
    stat.split      = CW'(sz_r) >= CW'(need_r) + CW'(2);
    stat.has_next   = nf_q[AW];
    stat.prev_valid = prev_r[AW];
    stat.clr_last   = (clr_r == AW'(ARENA_UNITS - 1));
    stat.out_busy   = ov_r && !out_rsp.ready;
  end

  always_comb begin
    case (cmd)
      ffa_pkg::ST_WRD: rd_addr = cur_r[AW-1:0];
      ffa_pkg::ST_C1:  rd_addr = node_r;
      ffa_pkg::ST_C2:  rd_addr = nf_q[AW-1:0];
      ffa_pkg::ST_C5:  rd_addr = prev_r[AW-1:0];
      default:         rd_addr = cur_r[AW-1:0];
    endcase
  end

  always_comb begin
    bs_we = 1'b0;
    bs_wa = clr_r;
    bs_wd = '0;
    nf_we = 1'b0;
    nf_wa = node_r;
    nf_wd = '0;
    case (cmd)
      ffa_pkg::ST_CLR: begin
        bs_we = 1'b1;
        bs_wd = (clr_r == '0) ? AW'(arena_r - ffa_pkg::CFG_W'(1)) : '0;
        nf_we = 1'b1;
        nf_wa = clr_r;
      end
      ffa_pkg::ST_ASPL: begin
        bs_we = stat.split;
        bs_wa = n_unit;
        bs_wd = AW'(CW'(sz_r) - CW'(1) - CW'(need_r));
        nf_we = stat.split;
        nf_wa = n_unit;
        nf_wd = nfc_r;
      end
      ffa_pkg::ST_AS3: begin
        bs_we = 1'b1;
        bs_wa = c_r;
        bs_wd = AW'(need_r);
        nf_we = 1'b1;
        nf_wa = c_r;
        nf_wd = {1'b1, n_unit};
      end
      ffa_pkg::ST_ALNK: begin
        nf_we = prev_r[AW];
        nf_wa = prev_r[AW-1:0];
        nf_wd = link_r;
      end
      ffa_pkg::ST_RPLC: begin
        nf_we = 1'b1;
        nf_wd = {1'b1, c_r};
      end
      ffa_pkg::ST_RTAIL: begin
        nf_we = 1'b1;
      end
      ffa_pkg::ST_RLNK: begin
        nf_we = prev_r[AW];
        nf_wa = prev_r[AW-1:0];
        nf_wd = {1'b1, node_r};
      end
      ffa_pkg::ST_C3: begin
        bs_we = (adj_n == CW'(nxn_r[AW-1:0]));
        bs_wa = node_r;
        bs_wd = AW'(CW'(bsn_r) + CW'(1) + CW'(bs_q));
        nf_we = bs_we;
        nf_wd = nf_q;
      end
      ffa_pkg::ST_C6: begin
        bs_we = (adj_p == CW'(node_r));
        bs_wa = prev_r[AW-1:0];
        bs_wd = AW'(CW'(bs_q) + CW'(1) + CW'(bsn_r));
        nf_we = bs_we;
        nf_wa = prev_r[AW-1:0];
        nf_wd = nxn_r;
      end
      default: begin
        bs_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (bs_we) bs_mem[bs_wa] <= bs_wd;
    if (nf_we) nf_mem[nf_wa] <= nf_wd;
    bs_q <= bs_mem[rd_addr];
    nf_q <= nf_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_r <= ffa_pkg::CFG_W'(ARST);
      clr_r   <= '0;
      head_r  <= {1'b1, {AW{1'b0}}};
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        arena_r <= cfg_cl;
        clr_r   <= '0;
      end else if (cmd == ffa_pkg::ST_CLR) begin
        clr_r  <= clr_r + AW'(1);
        head_r <= {1'b1, {AW{1'b0}}};
      end
      if (cmd == ffa_pkg::ST_ALNK && !prev_r[AW]) head_r <= link_r;
      if (cmd == ffa_pkg::ST_RLNK && !prev_r[AW]) head_r <= {1'b1, node_r};
      if (cmd == ffa_pkg::ST_FIN && !stat.out_busy) ov_r <= 1'b1;
      else if (out_rsp.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r    <= in_req.func;
      need_r    <= TW'(prod >> SH);
      node_r    <= AW'(in_req.release_unit - ffa_pkg::UNIT_W'(1));
      cur_r     <= head_r;
      prev_r    <= '0;
      steps_r   <= '0;
      res_ok_r  <= 1'b0;
      res_pay_r <= '0;
    end
    case (cmd)
      ffa_pkg::ST_WRD: c_r <= cur_r[AW-1:0];
      ffa_pkg::ST_WEV: begin
        sz_r  <= bs_q;
        nfc_r <= nf_q;
        if ((func_r == ffa_pkg::FUNC_ALLOC) ? !stat.fit : !(stat.dup || stat.precedes)) begin
          prev_r  <= {1'b1, c_r};
          cur_r   <= nf_q;
          steps_r <= steps_r + STW'(1);
        end
      end
      ffa_pkg::ST_ASPL: link_r <= stat.split ? {1'b1, n_unit} : nfc_r;
      ffa_pkg::ST_ALNK: begin
        res_ok_r  <= 1'b1;
        res_pay_r <= ffa_pkg::UNIT_W'(LW'(c_r) + LW'(1));
      end
      ffa_pkg::ST_RLNK: res_ok_r <= 1'b1;
      ffa_pkg::ST_C2: begin
        bsn_r <= bs_q;
        nxn_r <= nf_q;
      end
      ffa_pkg::ST_C3: begin
        if (adj_n == CW'(nxn_r[AW-1:0])) begin
          bsn_r <= AW'(CW'(bsn_r) + CW'(1) + CW'(bs_q));
          nxn_r <= nf_q;
        end
      end
      ffa_pkg::ST_FIN: begin
        if (!stat.out_busy) begin
          ok_r  <= res_ok_r;
          pay_r <= res_pay_r;
        end
      end
      default: c_r <= c_r;
    endcase
  end

  assign out_rsp.valid        = ov_r;
  assign out_rsp.ok           = ok_r;
  assign out_rsp.payload_unit = pay_r;

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_req.ready)
    else $error("request taken right after a configuration write");

  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_req.ready)
    else $error("second request taken while one is in flight");

  a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(cmd == ffa_pkg::ST_FIN))
    else $error("response raised outside the finish step");

endmodule
